// ===== src/shp_pkg.sv =====
// shared types, constants and register map for the solder heater panel controller
// used by every module of the block; depends on nothing
package shp_pkg;

  // item kinds carried on the input tuser
  localparam logic [1:0] CmdTick   = 2'd0;
  localparam logic [1:0] CmdRemote = 2'd1;
  localparam logic [1:0] CmdSample = 2'd2;

  // remote command bytes
  localparam logic [7:0] CodePower   = 8'd69;
  localparam logic [7:0] CodeFanUp   = 8'd25;
  localparam logic [7:0] CodeFanDown = 8'd22;
  localparam logic [7:0] CodeLedUp   = 8'd9;
  localparam logic [7:0] CodeLedDown = 8'd13;
  localparam logic [7:0] CodeSetUp   = 8'd21;
  localparam logic [7:0] CodeSetDown = 8'd7;

  // register indexes on the configuration port
  localparam logic [1:0] RegMargin  = 2'd0;
  localparam logic [1:0] RegLockout = 2'd1;
  localparam logic [1:0] RegIgnore  = 2'd2;
  localparam logic [1:0] RegSpMax   = 2'd3;

  // register reset values
  localparam logic [7:0]  MarginRst  = 8'd22;
  localparam logic [13:0] LockoutRst = 14'd10000;
  localparam logic [9:0]  IgnoreRst  = 10'd650;
  localparam logic [8:0]  SpMaxRst   = 9'd500;

  // state reset values and limits
  localparam logic [8:0]  TargetRst   = 9'd300;
  localparam logic [12:0] LastTempRst = 13'd600;
  localparam logic [2:0]  LevelMax    = 3'd5;
  localparam logic [13:0] SwitchSat   = 14'd16383;
  localparam logic [9:0]  CommandSat  = 10'd1023;
  localparam logic [8:0]  LedUnit     = 9'd51;

  // reciprocal of 100 for the calibration, exact for dividends below 3072
  localparam logic [12:0] Recip100    = 13'd5243;
  localparam int          Recip100Sh  = 19;

  // widths of the stream words
  localparam int InDataW  = 24;
  localparam int OutDataW = 56;

  typedef struct packed {
    logic [7:0]  margin;
    logic [13:0] lockout_ms;
    logic [9:0]  ignore_ms;
    logic [8:0]  setpoint_max;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  ir_code;
    logic [11:0] sensor_raw;
  } item_t;

  typedef struct packed {
    logic        power_on;
    logic        heater_on;
    logic        fan_enable;
    logic [8:0]  fan_compare;
    logic [7:0]  led_duty;
    logic [8:0]  setpoint;
    logic [2:0]  fan_level;
    logic [2:0]  led_level;
    logic [12:0] temp_quarters;
    logic        command_taken;
  } result_t;

endpackage

// ===== src/shp_cfg_regs.sv =====
// configuration registers behind a simple apb-style port
// depends on shp_pkg for the register map and reset values
module shp_cfg_regs
  import shp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.margin       <= MarginRst;
      cfg_q.lockout_ms   <= LockoutRst;
      cfg_q.ignore_ms    <= IgnoreRst;
      cfg_q.setpoint_max <= SpMaxRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegMargin:  cfg_q.margin       <= pwdata[7:0];
        RegLockout: cfg_q.lockout_ms   <= pwdata[13:0];
        RegIgnore:  cfg_q.ignore_ms    <= pwdata[9:0];
        RegSpMax:   cfg_q.setpoint_max <= pwdata[8:0];
        default:    ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      RegMargin:  prdata = {24'd0, cfg_q.margin};
      RegLockout: prdata = {18'd0, cfg_q.lockout_ms};
      RegIgnore:  prdata = {22'd0, cfg_q.ignore_ms};
      RegSpMax:   prdata = {23'd0, cfg_q.setpoint_max};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/shp_calib.sv =====
// thermocouple calibration: adds trunc(deg)*12/400 whole degrees to a quarter-degree reading
// depends on shp_pkg for the reciprocal constant
module shp_calib
  import shp_pkg::*;
(
  input  logic [11:0] raw_i,
  output logic [12:0] temp_o
);

  logic [9:0]  deg;
  logic [11:0] deg_x3;
  logic [24:0] prod;
  logic [4:0]  corr;

  // deg*12/400 == deg*3/100, the divide by 100 done with a reciprocal multiply
  assign deg    = raw_i[11:2];
  assign deg_x3 = {1'b0, deg, 1'b0} + {2'b00, deg};
  assign prod   = {13'd0, deg_x3} * {12'd0, Recip100};
  assign corr   = prod[Recip100Sh +: 5];
  assign temp_o = {1'b0, raw_i} + {6'd0, corr, 2'b00};

endmodule

// ===== src/shp_core.sv =====
// controller state and the per-word update: timers, remote codes, heater switching
// depends on shp_pkg and shp_calib
module shp_core
  import shp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic        powered_q, powered_d;
  logic        heating_q, heating_d;
  logic [8:0]  target_q, target_d;
  logic [2:0]  fan_q, fan_d;
  logic [2:0]  led_q, led_d;
  logic [13:0] since_sw_q, since_sw_d;
  logic        ignoring_q, ignoring_d;
  logic [9:0]  since_cmd_q, since_cmd_d;
  logic [12:0] temp_q, temp_d;
  logic        taken;

  logic [12:0] cal_temp;
  logic        still_ign;
  logic        sw_ok;
  logic        above;
  logic [10:0] diff;
  logic signed [13:0] thr;
  logic signed [13:0] temp_s;
  logic [9:0]  sp_up;
  logic [9:0]  sp_dn;
  logic [9:0]  sp_max_x;
  logic [8:0]  sp_up_c;
  logic [8:0]  sp_dn_c;
  logic [8:0]  led_prod;

  shp_calib u_calib (
    .raw_i  (item_i.sensor_raw),
    .temp_o (cal_temp)
  );

  // level stepping, saturating at 0 and the top level
  function automatic logic [2:0] step_level(input logic [2:0] lvl, input logic up);
    logic [2:0] r;
    if (up) begin
      r = (lvl >= LevelMax) ? LevelMax : lvl + 3'd1;
    end else if (lvl == 3'd0) begin
      r = 3'd0;
    end else begin
      r = (lvl > LevelMax) ? LevelMax : lvl - 3'd1;
    end
    return r;
  endfunction

  // setpoint steps, clamped to the configured maximum
  assign sp_max_x = {1'b0, cfg_i.setpoint_max};
  assign sp_up    = {1'b0, target_q} + 10'd1;
  assign sp_dn    = (target_q == 9'd0) ? 10'd0 : {1'b0, target_q} - 10'd1;
  assign sp_up_c  = (sp_up > sp_max_x) ? cfg_i.setpoint_max : sp_up[8:0];
  assign sp_dn_c  = (sp_dn > sp_max_x) ? cfg_i.setpoint_max : sp_dn[8:0];

  // ignore window still open once its expiry is taken into account
  assign still_ign = ignoring_q & ~(since_cmd_q > cfg_i.ignore_ms);

  // signed threshold, four times setpoint minus margin
  assign diff   = {2'b00, target_q} - {3'b000, cfg_i.margin};
  assign thr    = {diff[10], diff, 2'b00};
  assign temp_s = {1'b0, cal_temp};
  assign above  = temp_s >= thr;
  assign sw_ok  = since_sw_q > cfg_i.lockout_ms;

  // next-state logic for one word
  always_comb begin
    powered_d   = powered_q;
    heating_d   = heating_q;
    target_d    = target_q;
    fan_d       = fan_q;
    led_d       = led_q;
    since_sw_d  = since_sw_q;
    ignoring_d  = ignoring_q;
    since_cmd_d = since_cmd_q;
    temp_d      = temp_q;
    taken       = 1'b0;
    unique case (item_i.cmd)
      CmdTick: begin
        if (since_sw_q != SwitchSat) since_sw_d = since_sw_q + 14'd1;
        if (since_cmd_q != CommandSat) since_cmd_d = since_cmd_q + 10'd1;
      end
      CmdRemote: begin
        ignoring_d = still_ign;
        taken      = ~still_ign;
        if (!still_ign) begin
          if (powered_q) begin
            unique case (item_i.ir_code)
              CodePower:   powered_d = 1'b0;
              CodeSetUp:   target_d  = sp_up_c;
              CodeSetDown: target_d  = sp_dn_c;
              CodeFanUp:   fan_d     = step_level(fan_q, 1'b1);
              CodeFanDown: fan_d     = step_level(fan_q, 1'b0);
              CodeLedUp:   led_d     = step_level(led_q, 1'b1);
              CodeLedDown: led_d     = step_level(led_q, 1'b0);
              default:     ;
            endcase
            if (item_i.ir_code != CodeSetUp && item_i.ir_code != CodeSetDown) begin
              ignoring_d  = 1'b1;
              since_cmd_d = 10'd0;
            end
          end else if (item_i.ir_code == CodePower) begin
            powered_d = 1'b1;
          end
        end
      end
      CmdSample: begin
        if (powered_q) begin
          temp_d = cal_temp;
          // on while below the threshold, off at or above it
          if (sw_ok && (heating_q == above)) begin
            heating_d  = ~heating_q;
            since_sw_d = 14'd0;
          end
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powered_q   <= 1'b0;
      heating_q   <= 1'b0;
      target_q    <= TargetRst;
      fan_q       <= 3'd0;
      led_q       <= 3'd0;
      since_sw_q  <= 14'd0;
      ignoring_q  <= 1'b0;
      since_cmd_q <= 10'd0;
      temp_q      <= LastTempRst;
    end else if (fire_i) begin
      powered_q   <= powered_d;
      heating_q   <= heating_d;
      target_q    <= target_d;
      fan_q       <= fan_d;
      led_q       <= led_d;
      since_sw_q  <= since_sw_d;
      ignoring_q  <= ignoring_d;
      since_cmd_q <= since_cmd_d;
      temp_q      <= temp_d;
    end
  end

  // result built from the updated state
  assign led_prod = {6'd0, led_d} * LedUnit;

  always_comb begin
    res_o.power_on      = powered_d;
    res_o.heater_on     = powered_d & heating_d;
    res_o.fan_enable    = powered_d & (fan_d != 3'd0);
    res_o.fan_compare   = powered_d ? {fan_d, 6'd0} : 9'd0;
    res_o.led_duty      = powered_d ? led_prod[7:0] : 8'd0;
    res_o.setpoint      = target_d;
    res_o.fan_level     = fan_d;
    res_o.led_level     = led_d;
    res_o.temp_quarters = temp_d;
    res_o.command_taken = taken;
  end

endmodule

// ===== src/solder_heater_panel_controller_top.sv =====
// solder heater panel controller, top level: stream ports, input and result registers
// depends on shp_pkg, shp_cfg_regs and shp_core
//
// usage:
//   input stream: one word per event; tuser selects the kind (0 millisecond
//   tick, 1 remote code, 2 thermocouple sample, 3 status only), tdata carries
//   the remote byte and the raw quarter-degree reading.
//   output stream: exactly one word per input word, in order, with the drive
//   values (power, heater, fan and led pwm, levels, setpoint, temperature)
//   and a flag telling whether a remote code was taken.
//   pipeline: an accepted word is registered in the input register, processed
//   into the result register and shown on the master side from there.
//   throughput: one word per cycle unless the receiver stalls; the state update is a
//   single combinational pass between the input register and the result register.
//   stall: while the receiver holds tready low the result register holds and
//   the input register still takes one more word if empty, then tready drops.
//   reset: asynchronous, active low; clears both stream stages, restores the
//   registers and the controller state (unpowered, setpoint 300 degrees,
//   temperature 150 degrees). no clearing pass, the block is ready at once. the user
//   writes registers via the apb port only while the stream is idle; not enforced.
module solder_heater_panel_controller_top
  import shp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // ir_code[7:0], sensor_raw[19:8], zeros
  input  logic [1:0]          s_axis_tuser,  // cmd[1:0]
  // master side
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // power_on, heater_on, fan_enable,
                                             // fan_compare[11:3], led_duty[19:12],
                                             // setpoint[28:20], fan_level[31:29],
                                             // led_level[34:32], temp_quarters[47:35],
                                             // command_taken[48], zeros
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t                cfg;
  item_t               in_item_q;
  logic                in_valid_q;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                advance;
  logic                fire;
  result_t             res;

  shp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  shp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // stage handshake
  assign advance       = ~out_valid_q | m_axis_tready;
  assign fire          = in_valid_q & advance;
  assign s_axis_tready = ~in_valid_q | advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.cmd        <= s_axis_tuser;
      in_item_q.ir_code    <= s_axis_tdata[7:0];
      in_item_q.sensor_raw <= s_axis_tdata[19:8];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {7'd0, res.command_taken, res.temp_quarters, res.led_level,
                     res.fan_level, res.setpoint, res.led_duty, res.fan_compare,
                     res.fan_enable, res.heater_on, res.power_on};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== verif/shp_drive_checker.sv =====
// result checker for the solder heater panel controller: predicts every result word
// from the accepted input words and register writes, then compares field by field
// depends on shp_pkg
module shp_drive_checker
  import shp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // ir_code[7:0], sensor_raw[19:8], zeros
  input  logic [1:0]          s_axis_tuser,  // cmd[1:0]
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,  // power_on, heater_on, fan_enable,
                                             // fan_compare[11:3], led_duty[19:12],
                                             // setpoint[28:20], fan_level[31:29],
                                             // led_level[34:32], temp_quarters[47:35],
                                             // command_taken[48], zeros
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  mismatches_o,
  output int                  pending_o
);

  localparam int FanUnit = 64;

  // register copy and controller state as the predictor sees them
  cfg_t        regs;
  logic        stn_on;
  logic        heat_req;
  logic        quiet;
  logic [8:0]  sp;
  logic [2:0]  fan_lvl;
  logic [2:0]  led_lvl;
  logic [13:0] ms_since_switch;
  logic [9:0]  ms_since_cmd;
  logic [12:0] temp_q;

  // expected result words, oldest first
  result_t drive_expected[$];

  function automatic logic [2:0] step_level(input logic [2:0] lvl, input logic up);
    if (up) return (lvl >= LevelMax) ? LevelMax : lvl + 3'd1;
    if (lvl == 3'd0) return 3'd0;
    return (lvl > LevelMax) ? LevelMax : lvl - 3'd1;
  endfunction

  // one degree step, saturating at zero and at the programmed maximum
  function automatic logic [8:0] step_setpoint(input logic [8:0] t, input logic up);
    int v;
    v = int'(t);
    if (up) v = v + 1;
    else if (v > 0) v = v - 1;
    if (v > int'(regs.setpoint_max)) v = int'(regs.setpoint_max);
    return v[8:0];
  endfunction

  // applies one input word to the state and forms the drive values
  task automatic advance_panel(input item_t it, output result_t r);
    int   deg;
    int   cal;
    int   thr;
    logic above;
    logic taken;
    taken = 1'b0;
    case (it.cmd)
      CmdTick: begin
        if (ms_since_switch != SwitchSat) ms_since_switch = ms_since_switch + 14'd1;
        if (ms_since_cmd != CommandSat) ms_since_cmd = ms_since_cmd + 10'd1;
      end
      CmdRemote: begin
        // an expired window closes before the code is looked at
        if (quiet && ms_since_cmd > regs.ignore_ms) quiet = 1'b0;
        if (!quiet) begin
          taken = 1'b1;
          if (stn_on) begin
            case (it.ir_code)
              CodePower:   stn_on = 1'b0;
              CodeSetUp:   sp = step_setpoint(sp, 1'b1);
              CodeSetDown: sp = step_setpoint(sp, 1'b0);
              CodeFanUp:   fan_lvl = step_level(fan_lvl, 1'b1);
              CodeFanDown: fan_lvl = step_level(fan_lvl, 1'b0);
              CodeLedUp:   led_lvl = step_level(led_lvl, 1'b1);
              CodeLedDown: led_lvl = step_level(led_lvl, 1'b0);
              default: ;
            endcase
            if (it.ir_code != CodeSetUp && it.ir_code != CodeSetDown) begin
              quiet = 1'b1;
              ms_since_cmd = '0;
            end
          end else if (it.ir_code == CodePower) begin
            stn_on = 1'b1;
          end
        end
      end
      CmdSample: begin
        if (stn_on) begin
          deg = int'(it.sensor_raw) >> 2;
          cal = int'(it.sensor_raw) + 4 * ((deg * 12) / 400);
          temp_q = cal[12:0];
          // threshold may go negative, compare signed
          thr = 4 * (int'(sp) - int'(regs.margin));
          above = (int'(temp_q) >= thr);
          if (heat_req && above && ms_since_switch > regs.lockout_ms) begin
            heat_req = 1'b0;
            ms_since_switch = '0;
          end
          if (!heat_req && !above && ms_since_switch > regs.lockout_ms) begin
            heat_req = 1'b1;
            ms_since_switch = '0;
          end
        end
      end
      default: ;
    endcase
    r.power_on      = stn_on;
    r.heater_on     = stn_on && heat_req;
    r.fan_enable    = stn_on && (fan_lvl != 3'd0);
    r.fan_compare   = stn_on ? 9'(fan_lvl * FanUnit) : 9'd0;
    r.led_duty      = stn_on ? 8'(led_lvl * LedUnit) : 8'd0;
    r.setpoint      = sp;
    r.fan_level     = fan_lvl;
    r.led_level     = led_lvl;
    r.temp_quarters = temp_q;
    r.command_taken = taken;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin
    item_t   it;
    result_t want;
    result_t got;
    if (!rst_ni) begin
      regs            = '{margin: MarginRst, lockout_ms: LockoutRst,
                          ignore_ms: IgnoreRst, setpoint_max: SpMaxRst};
      stn_on          = 1'b0;
      heat_req        = 1'b0;
      quiet           = 1'b0;
      sp              = TargetRst;
      fan_lvl         = '0;
      led_lvl         = '0;
      ms_since_switch = '0;
      ms_since_cmd    = '0;
      temp_q          = LastTempRst;
      drive_expected.delete();
      mismatches_o    = 0;
    end else begin
      // result word against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got.power_on      = m_axis_tdata[0];
        got.heater_on     = m_axis_tdata[1];
        got.fan_enable    = m_axis_tdata[2];
        got.fan_compare   = m_axis_tdata[11:3];
        got.led_duty      = m_axis_tdata[19:12];
        got.setpoint      = m_axis_tdata[28:20];
        got.fan_level     = m_axis_tdata[31:29];
        got.led_level     = m_axis_tdata[34:32];
        got.temp_quarters = m_axis_tdata[47:35];
        got.command_taken = m_axis_tdata[48];
        if (drive_expected.size() == 0) begin
          $error("result word arrived with no expectation waiting");
          mismatches_o++;
        end else begin
          want = drive_expected.pop_front();
          check_field("power_on", want.power_on, got.power_on);
          check_field("heater_on", want.heater_on, got.heater_on);
          check_field("fan_enable", want.fan_enable, got.fan_enable);
          check_field("fan_compare", want.fan_compare, got.fan_compare);
          check_field("led_duty", want.led_duty, got.led_duty);
          check_field("setpoint", want.setpoint, got.setpoint);
          check_field("fan_level", want.fan_level, got.fan_level);
          check_field("led_level", want.led_level, got.led_level);
          check_field("temp_quarters", want.temp_quarters, got.temp_quarters);
          check_field("command_taken", want.command_taken, got.command_taken);
        end
      end
      // register write on the access cycle
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegMargin:  regs.margin       = pwdata[7:0];
          RegLockout: regs.lockout_ms   = pwdata[13:0];
          RegIgnore:  regs.ignore_ms    = pwdata[9:0];
          RegSpMax:   regs.setpoint_max = pwdata[8:0];
          default: ;
        endcase
      end
      // accepted input word
      if (s_axis_tvalid && s_axis_tready) begin
        it.cmd        = s_axis_tuser;
        it.ir_code    = s_axis_tdata[7:0];
        it.sensor_raw = s_axis_tdata[19:8];
        advance_panel(it, want);
        drive_expected.push_back(want);
      end
    end
    pending_o = drive_expected.size();
  end

endmodule

// ===== verif/solder_heater_panel_controller_top_tb.sv =====
// testbench top for the solder heater panel controller: clock, reset, stream and
// register stimulus with random gaps and stalls, and the verdict
// depends on shp_pkg, shp_drive_checker and the block itself
module solder_heater_panel_controller_top_tb;
  import shp_pkg::*;

  localparam int         CycleLimit = 400000;
  localparam logic [1:0] CmdStatus  = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // ir_code[7:0], sensor_raw[19:8], zeros
  logic [1:0]          s_axis_tuser = '0;   // cmd[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // power_on, heater_on, fan_enable,
                                            // fan_compare[11:3], led_duty[19:12],
                                            // setpoint[28:20], fan_level[31:29],
                                            // led_level[34:32], temp_quarters[47:35],
                                            // command_taken[48], zeros
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  int          mismatches;
  int          pending;
  int          cycles = 0;
  logic        no_idle = 1'b0;
  logic        station_on = 1'b0;
  logic [8:0]  seen_setpoint = TargetRst;
  logic [7:0]  cur_margin = MarginRst;

  solder_heater_panel_controller_top u_top (.*);

  shp_drive_checker u_check (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // last seen drive state steers the random stimulus
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      station_on    <= m_axis_tdata[0];
      seen_setpoint <= m_axis_tdata[28:20];
    end
  end

  // receiver: random stall before each result word
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // one input word after a random gap, returns at the falling edge after acceptance
  task automatic send_item(input logic [1:0] kind, input logic [7:0] code,
                           input logic [11:0] raw);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {4'd0, raw, code};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold off until every expected word has come back
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_config(input int unsigned margin, lockout, ignore, spmax);
    wait_drained();
    write_reg(RegMargin, margin);
    write_reg(RegLockout, lockout);
    write_reg(RegIgnore, ignore);
    write_reg(RegSpMax, spmax);
    cur_margin = margin[7:0];
  endtask

  // reading close to the heater threshold, sometimes anywhere
  function automatic logic [11:0] near_threshold();
    int thr;
    int raw;
    if ($urandom_range(0, 9) == 0) return 12'($urandom);
    thr = 4 * (int'(seen_setpoint) - int'(cur_margin));
    if (thr <= 0) raw = $urandom_range(0, 400);
    else raw = thr * 100 / 103 + int'($urandom_range(0, 40)) - 20;
    if (raw < 0) raw = 0;
    if (raw > 4095) raw = 4095;
    return raw[11:0];
  endfunction

  // mostly powered operation with ticks, codes and samples mixed
  task automatic random_run(input int count);
    int         pick;
    logic [7:0] code;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_item(CmdTick, 8'($urandom), 12'($urandom));
      end else if (pick < 72) begin
        pick = $urandom_range(0, 99);
        if (pick < (station_on ? 3 : 50)) begin
          code = CodePower;
        end else begin
          case ($urandom_range(0, 7))
            0: code = CodeSetUp;
            1: code = CodeSetDown;
            2: code = CodeFanUp;
            3: code = CodeFanDown;
            4: code = CodeLedUp;
            5: code = CodeLedDown;
            6: code = 8'($urandom);
            default: code = 8'($urandom_range(0, 31));
          endcase
        end
        send_item(CmdRemote, code, 12'($urandom));
      end else if (pick < 97) begin
        send_item(CmdSample, 8'($urandom), near_threshold());
      end else begin
        send_item(CmdStatus, 8'($urandom), 12'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int unsigned margin;
    int unsigned spmax;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: unpowered behavior, power up, ignore window drops codes
    send_item(CmdStatus, 8'hFF, 12'hFFF);
    send_item(CmdTick, 8'h00, 12'h000);
    send_item(CmdRemote, CodeFanUp, 12'h000);
    send_item(CmdSample, 8'h00, 12'hFFF);
    send_item(CmdRemote, CodePower, 12'h000);
    send_item(CmdSample, 8'h00, 12'h000);
    send_item(CmdSample, 8'h00, 12'hFFF);
    send_item(CmdRemote, 8'hFF, 12'h000);
    send_item(CmdRemote, CodeFanUp, 12'h000);
    send_item(CmdRemote, CodeSetUp, 12'h000);

    // zero margin, lockout and window: levels, setpoint steps, heater across power off
    apply_config(0, 0, 0, 511);
    send_item(CmdTick, 8'h00, 12'h000);
    send_item(CmdRemote, CodeFanUp, 12'h000);
    send_item(CmdRemote, CodeLedUp, 12'h000);
    send_item(CmdTick, 8'h00, 12'h000);
    send_item(CmdRemote, CodeLedUp, 12'h000);
    send_item(CmdTick, 8'h00, 12'h000);
    send_item(CmdRemote, CodeSetUp, 12'h000);
    send_item(CmdRemote, CodeSetDown, 12'h000);
    send_item(CmdRemote, CodeSetDown, 12'h000);
    send_item(CmdRemote, CodeFanDown, 12'h000);
    send_item(CmdTick, 8'h00, 12'h000);
    send_item(CmdRemote, CodeLedDown, 12'h000);
    send_item(CmdTick, 8'h00, 12'h000);
    send_item(CmdSample, 8'h00, 12'h000);
    send_item(CmdRemote, CodePower, 12'h000);
    send_item(CmdTick, 8'h00, 12'h000);
    send_item(CmdRemote, CodePower, 12'h000);
    send_item(CmdTick, 8'h00, 12'h000);
    send_item(CmdSample, 8'h00, 12'hFFF);

    // longest lockout and window: the command timer runs into saturation
    apply_config(22, 16382, 1022, 500);
    no_idle = 1'b1;
    repeat (1030) send_item(CmdTick, 8'h00, 12'h000);
    no_idle = 1'b0;
    send_item(CmdSample, 8'h00, 12'h000);
    send_item(CmdRemote, CodeFanUp, 12'h000);
    send_item(CmdSample, 8'h00, 12'hFFF);

    // setpoint sweep into the top of the range
    apply_config(0, 3, 2, 511);
    if (!station_on) send_item(CmdRemote, CodePower, 12'h000);
    no_idle = 1'b1;
    repeat (230) send_item(CmdRemote, CodeSetUp, 12'($urandom));
    no_idle = 1'b0;

    random_run(70);
    apply_config(22, 5, 3, 500);
    random_run(70);
    apply_config(255, 0, 0, 0);
    random_run(70);
    apply_config(0, 40, 12, 511);
    random_run(70);

    // random settings, the maximum often just below the current setpoint
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      margin = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60);
      if ($urandom_range(0, 1) == 0) spmax = $urandom_range(0, 511);
      else spmax = (seen_setpoint > 20) ? seen_setpoint - $urandom_range(0, 20) : 0;
      apply_config(margin, $urandom_range(0, 60), $urandom_range(0, 20), spmax);
      random_run(50);
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== solder_heater_panel_controller_top.f =====
src/shp_pkg.sv
src/shp_cfg_regs.sv
src/shp_calib.sv
src/shp_core.sv
src/solder_heater_panel_controller_top.sv
verif/shp_drive_checker.sv
verif/solder_heater_panel_controller_top_tb.sv
